>>> design/mrr_pkg.sv
package mrr_pkg;

  localparam int unsigned MaxFrameDefault = 256;
  localparam int unsigned MinDecide       = 6;
  localparam logic [7:0]  SlaveAddrReset  = 8'h02;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;

  localparam logic [7:0] FuncReadHolding  = 8'h03;
  localparam logic [7:0] FuncReadInput    = 8'h04;
  localparam logic [7:0] FuncWriteSingle  = 8'h06;
  localparam logic [7:0] FuncWriteMulti   = 8'h10;

  localparam logic [8:0] WriteSingleLen   = 9'd8;
  localparam logic [8:0] ReadHeaderLen    = 9'd5;

  typedef enum logic [2:0] {
    STATUS_BUSY      = 3'd0,
    STATUS_ADDR_MISS = 3'd1,
    STATUS_BAD_FUNC  = 3'd2,
    STATUS_TOO_LONG  = 3'd3,
    STATUS_GOOD      = 3'd4,
    STATUS_CRC_ERR   = 3'd5
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [8:0] frame_length;
    logic [7:0] function_code;
    logic       online;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> design/modbus_rtu_reply_receiver.sv
// A byte goes through the input register, one pass of frame/CRC logic, then the output register.
// Throughput: one byte per cycle while the input side is not stalled.
// The input side stalls only while the output register holds a result that is stalled.
// Reset (rst_ni low, async): slave address 2, frame state cleared, CRC 0xFFFF, online low,
// both stages empty.
module modbus_rtu_reply_receiver import mrr_pkg::*; #(
  parameter int unsigned MaxFrame = MaxFrameDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_slave_address_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [8:0] frame_length_o,
  output logic [7:0] function_code_o,
  output logic       online_o
);

  logic       out_free;
  logic       fire;
  logic [7:0] byte_q;
  result_t    core_res;
  result_t    out_res;

  assign cfg_ready_o = 1'b1;

  mrr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_free_i (out_free),
    .fire_o     (fire),
    .byte_o     (byte_q)
  );

  mrr_frame_core #(
    .MaxFrame (MaxFrame)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i (cfg_slave_address_i),
    .fire_i     (fire),
    .byte_i     (byte_q),
    .res_o      (core_res)
  );

  mrr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (core_res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign status_o        = out_res.status;
  assign frame_length_o  = out_res.frame_length;
  assign function_code_o = out_res.function_code;
  assign online_o        = out_res.online;

endmodule

>>> design/mrr_in_stage.sv
module mrr_in_stage import mrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       out_free_i,
  output logic       fire_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign fire_o     = valid_q && out_free_i;
  assign in_stall_o = valid_q && !out_free_i;
  assign take       = in_valid_i && !in_stall_o;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

>>> design/mrr_frame_core.sv
module mrr_frame_core import mrr_pkg::*; #(
  parameter int unsigned MaxFrame = MaxFrameDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_addr_i,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  logic [7:0]  slave_q;
  logic [8:0]  count_q, count_d;
  logic [8:0]  exp_q, exp_d;
  logic [7:0]  func_q, func_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] held_q, held_d;
  logic        online_q, online_d;

  logic [8:0]  count_inc;
  logic        skip;
  logic [15:0] crc_upd, held_upd;
  logic [8:0]  exp_upd;
  logic [7:0]  func_upd;
  logic        crc_ok;
  status_e     st;
  logic [8:0]  flen;

  assign count_inc = count_q + 9'd1;
  assign skip      = (exp_q != 9'd0) && (count_inc > exp_q);
  assign crc_upd   = (!skip && count_inc >= 9'd3) ? crc_feed(crc_q, held_q[15:8]) : crc_q;
  assign held_upd  = skip ? held_q : {held_q[7:0], byte_i};
  assign crc_ok    = (held_upd[15:8] == crc_upd[7:0]) && (held_upd[7:0] == crc_upd[15:8]);

  always_comb begin
    st       = STATUS_BUSY;
    flen     = 9'd0;
    func_upd = func_q;
    exp_upd  = exp_q;
    if (count_inc == 9'd1) begin
      if (byte_i != slave_q) begin
        st = STATUS_ADDR_MISS;
      end
    end else if (count_inc == 9'd2) begin
      func_upd = byte_i;
      if (byte_i == FuncWriteSingle) begin
        exp_upd = WriteSingleLen;
      end else if (byte_i != FuncReadHolding && byte_i != FuncReadInput &&
                   byte_i != FuncWriteMulti) begin
        st = STATUS_BAD_FUNC;
      end
    end else if (count_inc == 9'd3) begin
      if (func_q == FuncReadHolding || func_q == FuncReadInput) begin
        exp_upd = ReadHeaderLen + {1'b0, byte_i};
      end
    end
    if (st == STATUS_BUSY && count_inc >= 9'(MinDecide)) begin
      priority if (func_upd == FuncWriteMulti) begin
        st = STATUS_BAD_FUNC;
      end else if (exp_upd > 9'(MaxFrame)) begin
        st = STATUS_TOO_LONG;
      end else if (count_inc >= exp_upd) begin
        flen = exp_upd;
        st   = crc_ok ? STATUS_GOOD : STATUS_CRC_ERR;
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    exp_d    = exp_q;
    func_d   = func_q;
    crc_d    = crc_q;
    held_d   = held_q;
    online_d = online_q;
    if (fire_i) begin
      if (st == STATUS_GOOD) begin
        online_d = 1'b1;
      end
      if (st != STATUS_BUSY) begin
        count_d = 9'd0;
        exp_d   = 9'd0;
        func_d  = 8'd0;
        crc_d   = CrcInit;
        held_d  = 16'd0;
      end else begin
        count_d = count_inc;
        exp_d   = exp_upd;
        func_d  = func_upd;
        crc_d   = crc_upd;
        held_d  = held_upd;
      end
    end
  end

  assign res_o.status        = st;
  assign res_o.frame_length  = flen;
  assign res_o.function_code = func_upd;
  assign res_o.online        = online_q || (st == STATUS_GOOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q  <= SlaveAddrReset;
      count_q  <= 9'd0;
      exp_q    <= 9'd0;
      func_q   <= 8'd0;
      crc_q    <= CrcInit;
      held_q   <= 16'd0;
      online_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slave_q <= cfg_addr_i;
      end
      count_q  <= count_d;
      exp_q    <= exp_d;
      func_q   <= func_d;
      crc_q    <= crc_d;
      held_q   <= held_d;
      online_q <= online_d;
    end
  end

  a_online_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    online_q |=> online_q)
    else $error("online flag dropped");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < 9'd261)
    else $error("frame byte count out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && st != STATUS_BUSY) |=> (count_q == 9'd0 && crc_q == CrcInit))
    else $error("frame state not restarted after decision");

endmodule

>>> design/mrr_out_stage.sv
module mrr_out_stage import mrr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  result_t res_i,
  output logic    out_free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

endmodule
